FILE: rtl/tsf_pkg.sv
// Package for the TCP SYN target filter.
// Holds operation, verdict and status codes, sizes and shared types.
// No dependencies.
package tsf_pkg;

  localparam int unsigned TargetEntries = 128;
  localparam int unsigned EntryIdxW     = (TargetEntries > 1) ? $clog2(TargetEntries) : 1;
  localparam int unsigned EntryCntW     = $clog2(TargetEntries + 1);
  localparam int unsigned HeaderBytes   = 94;
  localparam int unsigned HdrIdxW       = $clog2(HeaderBytes);

  localparam int unsigned EthLen = 14;
  localparam int unsigned IpLen  = 20;
  localparam int unsigned TcpLen = 20;
  localparam logic [7:0] EthertypeHi = 8'h08;
  localparam logic [7:0] ProtoTcp    = 8'h06;

  typedef enum logic [1:0] {
    OpByte   = 2'd0,
    OpSet    = 2'd1,
    OpRemove = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VerdictPass  = 2'd0,
    VerdictDrop  = 2'd1,
    VerdictAbort = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusNotFound = 2'd2
  } status_e;

  // Sequencer states of the top level
  typedef enum logic [1:0] {SIdle, SWait, SOut} seq_e;

  // Sweep states of the table unit
  typedef enum logic [1:0] {TIdle, TScan, TWrite} tstate_e;

  // Search request from the sequencer to the table unit
  typedef struct packed {
    logic        start;
    logic        is_set;
    logic        is_remove;
    logic [31:0] addr;
    logic [15:0] port;
  } srch_req_t;

  // Search answer from the table unit
  typedef struct packed {
    logic        done;
    logic        hit;
    logic [15:0] port;
    logic        full;
  } srch_rsp_t;

endpackage

FILE: rtl/tsf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module tsf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/tsf_table.sv
// Target table: valid bits plus an address/port RAM swept by one comparator.
// Depends on tsf_pkg and tsf_ram.
module tsf_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsf_pkg::srch_req_t  req_i,
  output tsf_pkg::srch_rsp_t  rsp_o
);
  import tsf_pkg::*;

  tstate_e                   state_q, state_d;
  logic [EntryCntW-1:0]      idx_q, idx_d;
  logic                      rd_vld_q, rd_vld_d;
  logic [EntryIdxW-1:0]      rd_idx_q;
  logic [TargetEntries-1:0]  valid_q, valid_d;
  logic                      hit_q, hit_d;
  logic [EntryIdxW-1:0]      hit_idx_q, hit_idx_d;
  logic [15:0]               hit_port_q, hit_port_d;
  logic                      free_q, free_d;
  logic [EntryIdxW-1:0]      free_idx_q, free_idx_d;
  logic                      is_set_q, is_rem_q;
  logic [31:0]               addr_q;
  logic [15:0]               port_q;
  logic                      we;
  logic [EntryIdxW-1:0]      ram_addr;
  logic [47:0]               rdata;
  logic                      done_d;
  logic                      match;

  tsf_ram #(.Width(48), .Depth(TargetEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (ram_addr),
    .wdata_i ({addr_q, port_q}),
    .rdata_o (rdata)
  );

  // Compare the entry read last cycle
  assign match = rd_vld_q && valid_q[rd_idx_q] && (rdata[47:16] == addr_q);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rd_vld_d   = 1'b0;
    valid_d    = valid_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_port_d = hit_port_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    we         = 1'b0;
    ram_addr   = idx_q[EntryIdxW-1:0];
    done_d     = 1'b0;
    unique case (state_q)
      TIdle: begin
        if (req_i.start) begin
          state_d = TScan;
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      TScan: begin
        // Issue reads in order, check one entry per cycle
        if (idx_q < EntryCntW'(TargetEntries)) begin
          rd_vld_d = 1'b1;
          idx_d    = idx_q + 1'b1;
          if (!free_q && !valid_q[idx_q[EntryIdxW-1:0]]) begin
            free_d     = 1'b1;
            free_idx_d = idx_q[EntryIdxW-1:0];
          end
        end
        if (match && !hit_q) begin
          hit_d      = 1'b1;
          hit_idx_d  = rd_idx_q;
          hit_port_d = rdata[15:0];
        end
        if (!rd_vld_q && idx_q == EntryCntW'(TargetEntries)) begin
          state_d = TWrite;
        end
      end
      TWrite: begin
        state_d = TIdle;
        done_d  = 1'b1;
        if (is_set_q) begin
          if (hit_q) begin
            we = 1'b1; ram_addr = hit_idx_q;
          end else if (free_q) begin
            we = 1'b1; ram_addr = free_idx_q;
            valid_d[free_idx_q] = 1'b1;
          end
        end else if (is_rem_q && hit_q) begin
          valid_d[hit_idx_q] = 1'b0;
        end
      end
      default: state_d = TIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= TIdle;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      rsp_o    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      rsp_o    <= '{done: done_d, hit: hit_d, port: hit_port_d, full: !hit_d && !free_d};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= idx_q[EntryIdxW-1:0];
    hit_idx_q  <= hit_idx_d;
    hit_port_q <= hit_port_d;
    free_idx_q <= free_idx_d;
    if (state_q == TIdle && req_i.start) begin
      is_set_q <= req_i.is_set;
      is_rem_q <= req_i.is_remove;
      addr_q   <= req_i.addr;
      port_q   <= req_i.port;
    end
  end
endmodule

FILE: rtl/tcp_syn_target_filter.sv
// Top level of the TCP SYN target filter: header capture, frame checks, sequencer.
// Depends on tsf_pkg and tsf_table.
//
// Packet bytes are taken one per cycle while no search is pending and stored
// (first 94) in a header register file; the TCP ports, sequence number and
// flags are picked off as their bytes go by. The last byte of a frame and
// every table update start a linear search of the target table, one entry per
// cycle through a single address comparator on the table RAM, and hold the
// input until their result is shown; middle bytes do not hold the input. The
// table is empty after reset; no clearing pass is needed. A result waits in
// the output register until taken while the input stays open; a second
// result holds the input until the register frees.
module tcp_syn_target_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  packet_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] target_address_i,
  input  logic [15:0] target_port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic        event_valid_o,
  output logic [31:0] source_address_o,
  output logic [31:0] destination_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] destination_port_o,
  output logic [31:0] sequence_number_o,
  output logic [15:0] packet_length_o,
  output logic [1:0]  table_status_o
);
  import tsf_pkg::*;

  seq_e         state_q, state_d;
  logic [7:0]   hdr_q [HeaderBytes];
  logic [15:0]  count_q, count_d;
  logic [15:0]  len_q;
  logic         frame_q;   // request is end of frame
  logic         cand_q;    // frame is a SYN candidate
  logic [1:0]   pre_verdict_q;
  logic [1:0]   op_q;
  logic [31:0]  addr_q;
  logic [15:0]  port_q;
  logic         started_q;
  logic         out_valid_q;
  logic         out_free;
  logic         load;
  srch_req_t    req;
  srch_rsp_t    rsp;
  logic         accept;
  logic [1:0]   op;

  // TCP fields captured on the fly
  logic [3:0]   ihl_cur;
  logic [6:0]   tcp_cur;
  logic [15:0]  tcp_rel;
  logic         in_tcp;
  logic [15:0]  sport_q, dport_q;
  logic [31:0]  seqn_q;
  logic [7:0]   flags_q;

  // Frame fields from the header store
  logic [6:0]   tcp_off;
  logic [31:0]  saddr, daddr;
  logic [1:0]   pre_verdict;
  logic         cand;

  assign op       = operation_i;
  assign accept   = in_valid_i && in_ready_o;
  assign tcp_off  = 7'(EthLen) + {1'b0, hdr_q[14][3:0], 2'b00};
  assign saddr    = {hdr_q[26], hdr_q[27], hdr_q[28], hdr_q[29]};
  assign daddr    = {hdr_q[30], hdr_q[31], hdr_q[32], hdr_q[33]};

  // Locate the incoming byte within the TCP header
  assign ihl_cur  = (count_q == 16'(EthLen)) ? packet_byte_i[3:0] : hdr_q[14][3:0];
  assign tcp_cur  = 7'(EthLen) + {1'b0, ihl_cur, 2'b00};
  assign tcp_rel  = count_q - {9'd0, tcp_cur};
  assign in_tcp   = (count_q >= {9'd0, tcp_cur}) && (tcp_rel < 16'(TcpLen));

  // Classify the frame once it is fully captured
  always_comb begin
    pre_verdict = VerdictPass;
    cand        = 1'b0;
    if (len_q < 16'(EthLen)) begin
      pre_verdict = VerdictAbort;
    end else if (hdr_q[12] == EthertypeHi && hdr_q[13] == 8'h00) begin
      if (len_q < 16'(EthLen + IpLen)) begin
        pre_verdict = VerdictAbort;
      end else if (hdr_q[23] == ProtoTcp) begin
        if ({9'd0, len_q} < {18'd0, tcp_off} + 25'(TcpLen)) begin
          pre_verdict = VerdictAbort;
        end else begin
          cand = flags_q[1] && !flags_q[4];
        end
      end
    end
  end

  assign req = '{start: (state_q == SWait) && !rsp.done && !started_q,
                 is_set: op_q == OpSet, is_remove: op_q == OpRemove,
                 addr: frame_q ? daddr : addr_q, port: port_q};

  assign count_d = (count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;

  // Output register frees when empty or taken this cycle
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = ((state_q == SWait && rsp.done) || state_q == SOut) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept && ((op == OpByte && last_byte_i) || op == OpSet || op == OpRemove)) begin
          state_d = SWait;
        end
      end
      SWait:   if (rsp.done) state_d = out_free ? SIdle : SOut;
      SOut:    if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && op == OpByte) begin
        count_q <= last_byte_i ? 16'd0 : count_d;
      end
      if (state_q == SWait) begin
        started_q <= 1'b1;
      end else begin
        started_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture bytes and request fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op;
      addr_q <= target_address_i;
      port_q <= target_port_i;
      if (op == OpByte) begin
        if (count_q < 16'(HeaderBytes)) hdr_q[count_q[HdrIdxW-1:0]] <= packet_byte_i;
        if (in_tcp) begin
          case (tcp_rel[4:0]) inside
            5'd0, 5'd1:  sport_q <= {sport_q[7:0], packet_byte_i};
            5'd2, 5'd3:  dport_q <= {dport_q[7:0], packet_byte_i};
            [5'd4:5'd7]: seqn_q  <= {seqn_q[23:0], packet_byte_i};
            5'd13:       flags_q <= packet_byte_i;
            default:     ;
          endcase
        end
        len_q   <= count_d;
        frame_q <= last_byte_i;
      end else begin
        frame_q <= 1'b0;
      end
    end
    if (state_q == SWait && !started_q) begin
      pre_verdict_q <= pre_verdict;
      cand_q        <= cand;
    end
    // Build the result when the search answers and the register is free
    if (load) begin
      verdict_o             <= VerdictPass;
      event_valid_o         <= 1'b0;
      source_address_o      <= '0;
      destination_address_o <= '0;
      source_port_o         <= '0;
      destination_port_o    <= '0;
      sequence_number_o     <= '0;
      packet_length_o       <= '0;
      table_status_o        <= StatusOk;
      if (frame_q) begin
        packet_length_o <= len_q;
        verdict_o       <= pre_verdict_q;
        if (cand_q && rsp.hit && rsp.port == dport_q) begin
          verdict_o             <= VerdictDrop;
          event_valid_o         <= 1'b1;
          source_address_o      <= saddr;
          destination_address_o <= daddr;
          source_port_o         <= sport_q;
          destination_port_o    <= dport_q;
          sequence_number_o     <= seqn_q;
        end
      end else if (op_q == OpSet && rsp.full) begin
        table_status_o <= StatusFull;
      end else if (op_q == OpRemove && !rsp.hit) begin
        table_status_o <= StatusNotFound;
      end
    end
  end

  tsf_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );
endmodule
